// File: design/iida_pkg.sv
// Shared types, widths and helpers of the indexed insert/delete array unit.
package iida_pkg;

  localparam int unsigned DEPTH_DEFAULT = 256;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned POS_W         = 9;
  localparam int unsigned CMD_W         = 2;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned IN_TDATA_W    = 48;
  localparam int unsigned OUT_TDATA_W   = 16;
  localparam int unsigned TREE_FANIN    = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2
  } iida_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } iida_status_e;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } iida_ctrl_t;

  // Number of registered levels an OR tree needs to fold n bits into one.
  function automatic int unsigned tree_levels(int unsigned n);
    int unsigned w;
    int unsigned lv;
    w  = n;
    lv = 0;
    while (w > 1) begin
      w  = (w + TREE_FANIN - 1) / TREE_FANIN;
      lv = lv + 1;
    end
    return lv;
  endfunction

endpackage

// File: design/iida_cell.sv
// One storage cell of the array row: holds one entry, shifts with its neighbors, flags a match.
module iida_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned CNT_W = 9
) (
  input  logic                       clk_i,
  input  iida_pkg::iida_ctrl_t       ctrl_i,
  input  logic [CNT_W-1:0]           count_i,
  input  logic [iida_pkg::DATA_W-1:0] left_i,
  input  logic [iida_pkg::DATA_W-1:0] right_i,
  output logic [iida_pkg::DATA_W-1:0] entry_o,
  output logic                       match_o
);
  import iida_pkg::*;

  localparam logic [31:0] IDX_W = 32'(IDX);

  logic [DATA_W-1:0] entry_q, entry_d;
  logic              match_q, match_d;
  logic [31:0]       pos_w;
  logic [31:0]       cnt_w;

  assign pos_w = 32'(ctrl_i.pos);
  assign cnt_w = 32'(count_i);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      // open a slot: cells above the position take the word from below
      if (IDX_W > pos_w) begin
        entry_d = left_i;
      end else if (IDX_W == pos_w) begin
        entry_d = ctrl_i.value;
      end
    end else if (ctrl_i.del && (IDX_W >= pos_w)) begin
      entry_d = right_i;
    end
  end

  assign match_d = (entry_q == ctrl_i.value) && (IDX_W < cnt_w);

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= match_d;
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

// File: design/iida_or_tree.sv
// Registered OR reduction of the cells' match flags; every level is registered.
module iida_or_tree #(
  parameter int unsigned N = 256
) (
  input  logic         clk_i,
  input  logic [N-1:0] bits_i,
  output logic         any_o
);
  import iida_pkg::*;

  localparam int unsigned LVL = tree_levels(N);

  logic [N-1:0] tree_q [LVL];
  logic [N-1:0] tree_d [LVL];

  for (genvar l = 0; l < LVL; l++) begin : g_lvl
    logic [N-1:0] src;
    if (l == 0) begin : g_first
      assign src = bits_i;
    end else begin : g_next
      assign src = tree_q[l-1];
    end

    always_comb begin
      tree_d[l] = '0;
      for (int unsigned k = 0; k < N; k++) begin
        for (int unsigned j = 0; j < TREE_FANIN; j++) begin
          if (k * TREE_FANIN + j < N) begin
            tree_d[l][k] = tree_d[l][k] | src[k * TREE_FANIN + j];
          end
        end
      end
    end

    always_ff @(posedge clk_i) begin
      tree_q[l] <= tree_d[l];
    end
  end

  assign any_o = tree_q[LVL-1][0];

endmodule

// File: design/indexed_insert_delete_array_unit.sv
// Indexed insert/delete/search list: a row of DEPTH cells, one entry each, shifted in place.
// Each command word gives one result word. Insert and delete move every later entry at once;
// search compares all cells at once and folds their match flags through a registered OR
// tree of fan-in 16. Every command, insert and delete as well, waits out the tree depth, so
// a new command is taken only once the last result has been loaded. A finished result
// waits in the output register while the next command is taken.
// An out-of-range position reports bad index, an insert into a full list reports full.
module indexed_insert_delete_array_unit #(
  parameter int unsigned DEPTH = iida_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // value [31:0], position [40:32], zero [47:41]
  input  logic [iida_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // cmd [1:0]
  input  logic [iida_pkg::CMD_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // found [0], entry_count [9:1], zero [15:10]
  output logic [iida_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // status [1:0]
  output logic [iida_pkg::STATUS_W-1:0]    m_axis_tuser
);
  import iida_pkg::*;

  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned LVL    = tree_levels(DEPTH);
  localparam int unsigned WAIT_W = $clog2(LVL + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_HOLD = 3'b100
  } iida_state_e;

  iida_state_e       state_q, state_d;
  logic [WAIT_W-1:0] wait_q, wait_d;
  logic [CNT_W-1:0]  count_q, count_d;

  logic [DATA_W-1:0] s_value;
  logic [POS_W-1:0]  s_pos;
  logic              s_acc;
  logic [CMP_W-1:0]  pos_ext, cnt_ext;
  logic              full;
  logic              ins_ok, del_ok;
  iida_status_e      status;
  iida_ctrl_t        ctrl;

  logic [DATA_W-1:0] entry [DEPTH];
  logic [DEPTH-1:0]  match;
  logic              any_match;

  iida_status_e      pend_status_q;
  logic              pend_srch_q;
  logic [POS_W-1:0]  pend_count_q;
  logic              pend_found_q;

  logic              out_free, load, hold_found, found_src;
  logic              m_valid_q;
  iida_status_e      out_status_q;
  logic              out_found_q;
  logic [POS_W-1:0]  out_count_q;

  assign s_value       = s_axis_tdata[DATA_W-1:0];
  assign s_pos         = s_axis_tdata[DATA_W +: POS_W];
  assign s_axis_tready = (state_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign pos_ext = CMP_W'(s_pos);
  assign cnt_ext = CMP_W'(count_q);
  assign full    = (count_q == CNT_W'(DEPTH));

  always_comb begin
    status  = ST_DONE;
    ins_ok  = 1'b0;
    del_ok  = 1'b0;
    count_d = count_q;
    unique case (iida_cmd_e'(s_axis_tuser))
      CMD_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status = ST_BAD_INDEX;
        end else if (full) begin
          status = ST_FULL;
        end else begin
          ins_ok  = 1'b1;
          count_d = count_q + CNT_W'(1);
        end
      end
      CMD_DELETE: begin
        if (pos_ext >= cnt_ext) begin
          status = ST_BAD_INDEX;
        end else begin
          del_ok  = 1'b1;
          count_d = count_q - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign ctrl.ins   = s_acc && ins_ok;
  assign ctrl.del   = s_acc && del_ok;
  assign ctrl.pos   = s_pos;
  assign ctrl.value = s_value;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left, right;
    if (i == 0) begin : g_lo
      assign left = s_value;
    end else begin : g_lo_n
      assign left = entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi
      assign right = entry[i];
    end else begin : g_hi_n
      assign right = entry[i+1];
    end

    iida_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .left_i  (left),
      .right_i (right),
      .entry_o (entry[i]),
      .match_o (match[i])
    );
  end

  iida_or_tree #(
    .N (DEPTH)
  ) u_or_tree (
    .clk_i  (clk_i),
    .bits_i (match),
    .any_o  (any_match)
  );

  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d    = state_q;
    wait_d     = wait_q;
    load       = 1'b0;
    hold_found = 1'b0;
    found_src  = pend_found_q;
    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          state_d = S_SCAN;
          wait_d  = WAIT_W'(LVL);
        end
      end
      S_SCAN: begin
        if (wait_q != '0) begin
          wait_d = wait_q - WAIT_W'(1);
        end else begin
          found_src = any_match && pend_srch_q;
          if (out_free) begin
            load    = 1'b1;
            state_d = S_IDLE;
          end else begin
            hold_found = 1'b1;
            state_d    = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wait_q    <= '0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
      if (s_acc) begin
        count_q <= count_d;
      end
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // hold the command's outcome until the search flag is out of the tree
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      pend_status_q <= status;
      pend_srch_q   <= (iida_cmd_e'(s_axis_tuser) == CMD_SEARCH);
      pend_count_q  <= CMP_W'(count_d) >> 0 == '0 ? '0 : POS_W'(CMP_W'(count_d));
    end
    if (hold_found) begin
      pend_found_q <= found_src;
    end
    if (load) begin
      out_status_q <= pend_status_q;
      out_found_q  <= found_src;
      out_count_q  <= pend_count_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_count_q, out_found_q});

endmodule

// File: tb/sv/indexed_insert_delete_array_unit_tb.sv
// Self-checking testbench of the indexed insert/delete/search list unit.
module indexed_insert_delete_array_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iida_pkg::*;

  localparam int unsigned DEPTH      = iida_pkg::DEPTH_DEFAULT;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned STALL_MAX  = 3000;
  localparam int unsigned TAIL_WAIT  = 8;

  typedef struct packed {
    iida_cmd_e         op;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  position;
  } list_cmd_t;

  typedef struct packed {
    iida_status_e     status;
    logic             found;
    logic [POS_W-1:0] entry_count;
  } list_result_t;

  typedef struct {
    iida_cmd_e         op;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  position;
    bit                typed;
    iida_status_e      status;
    bit                found;
    logic [POS_W-1:0]  entry_count;
  } script_row_t;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [CMD_W-1:0]       s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;

  // Predictor state: the list contents and its length.
  logic [DATA_W-1:0] list_mem [DEPTH];
  int unsigned       list_len;
  bit                hit_full;

  list_result_t pending_results [$];
  int unsigned  mismatches;
  int unsigned  src_idle;
  int unsigned  sink_idle;
  int unsigned  stall_cycles;

  // Directed words; rows with typed set carry their result inline.
  script_row_t script [0:23] = '{
    '{CMD_DELETE, 32'h0000_0000, 9'd0,   1'b1, ST_BAD_INDEX, 1'b0, 9'd0},
    '{CMD_SEARCH, 32'h0000_0000, 9'd0,   1'b1, ST_DONE,      1'b0, 9'd0},
    '{CMD_INSERT, 32'h0000_0001, 9'd1,   1'b1, ST_BAD_INDEX, 1'b0, 9'd0},
    '{CMD_INSERT, 32'h1234_5678, 9'd256, 1'b1, ST_BAD_INDEX, 1'b0, 9'd0},
    '{CMD_INSERT, 32'h7FFF_FFFF, 9'd0,   1'b1, ST_DONE,      1'b0, 9'd1},
    '{CMD_INSERT, 32'h8000_0000, 9'd1,   1'b1, ST_DONE,      1'b0, 9'd2},
    '{CMD_INSERT, 32'hFFFF_FFFF, 9'd0,   1'b1, ST_DONE,      1'b0, 9'd3},
    '{CMD_INSERT, 32'h0000_0000, 9'd1,   1'b1, ST_DONE,      1'b0, 9'd4},
    '{CMD_SEARCH, 32'h8000_0000, 9'd256, 1'b1, ST_DONE,      1'b1, 9'd4},
    '{CMD_SEARCH, 32'h7FFF_FFFF, 9'd0,   1'b1, ST_DONE,      1'b1, 9'd4},
    '{CMD_SEARCH, 32'h0000_0001, 9'd0,   1'b1, ST_DONE,      1'b0, 9'd4},
    '{CMD_DELETE, 32'h0000_0000, 9'd4,   1'b1, ST_BAD_INDEX, 1'b0, 9'd4},
    '{CMD_DELETE, 32'hFFFF_FFFF, 9'd3,   1'b1, ST_DONE,      1'b0, 9'd3},
    '{CMD_SEARCH, 32'h8000_0000, 9'd0,   1'b1, ST_DONE,      1'b0, 9'd3},
    '{CMD_INSERT, 32'h0000_0002, 9'd4,   1'b1, ST_BAD_INDEX, 1'b0, 9'd3},
    '{CMD_DELETE, 32'h0000_0000, 9'd0,   1'b1, ST_DONE,      1'b0, 9'd2},
    '{CMD_SEARCH, 32'hFFFF_FFFF, 9'd0,   1'b1, ST_DONE,      1'b0, 9'd2},
    '{CMD_DELETE, 32'h0000_0000, 9'd256, 1'b1, ST_BAD_INDEX, 1'b0, 9'd2},
    '{CMD_INSERT, 32'hA5A5_A5A5, 9'd1,   1'b0, ST_DONE,      1'b0, 9'd0},
    '{CMD_SEARCH, 32'hA5A5_A5A5, 9'd0,   1'b0, ST_DONE,      1'b0, 9'd0},
    '{CMD_INSERT, 32'h5A5A_5A5A, 9'd3,   1'b0, ST_DONE,      1'b0, 9'd0},
    '{CMD_DELETE, 32'h0000_0000, 9'd1,   1'b0, ST_DONE,      1'b0, 9'd0},
    '{CMD_SEARCH, 32'h0000_0000, 9'd0,   1'b0, ST_DONE,      1'b0, 9'd0},
    '{CMD_INSERT, 32'h0000_0001, 9'd3,   1'b0, ST_DONE,      1'b0, 9'd0}
  };

  indexed_insert_delete_array_unit #(
    .DEPTH(DEPTH)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Apply one command to the predicted list and return its result word.
  function automatic list_result_t apply_command(list_cmd_t c);
    list_result_t r;
    int unsigned  p;
    p          = 32'(c.position);
    r.status   = ST_DONE;
    r.found    = 1'b0;
    case (c.op)
      CMD_INSERT: begin
        if (p > list_len) begin
          r.status = ST_BAD_INDEX;
        end else if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int unsigned j = list_len; j > p; j--) begin
            list_mem[IDX_W'(j)] = list_mem[IDX_W'(j-1)];
          end
          list_mem[IDX_W'(p)] = c.value;
          list_len++;
        end
      end
      CMD_DELETE: begin
        if (p >= list_len) begin
          r.status = ST_BAD_INDEX;
        end else begin
          for (int unsigned j = p; j + 1 < list_len; j++) begin
            list_mem[IDX_W'(j)] = list_mem[IDX_W'(j+1)];
          end
          list_len--;
        end
      end
      CMD_SEARCH: begin
        for (int unsigned j = 0; j < list_len; j++) begin
          if (list_mem[IDX_W'(j)] == c.value) r.found = 1'b1;
        end
      end
      default: ;
    endcase
    r.entry_count = list_len[POS_W-1:0];
    return r;
  endfunction

  // Extremes and a few repeats, so searches and duplicates hit often.
  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(99) >= 30) return $urandom;
    case ($urandom_range(5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'h0000_0001;
      default: return 32'hDEAD_BEEF;
    endcase
  endfunction

  function automatic list_cmd_t make_command(int unsigned ins_pct, int unsigned del_pct);
    list_cmd_t   c;
    int unsigned r;
    r          = $urandom_range(99);
    c.value    = pick_value();
    c.position = POS_W'($urandom_range(DEPTH));
    if (r < ins_pct) begin
      c.op = CMD_INSERT;
      if ($urandom_range(99) < 85) c.position = POS_W'($urandom_range(list_len));
    end else if (r < ins_pct + del_pct) begin
      c.op = CMD_DELETE;
      if (list_len > 0 && $urandom_range(99) < 85) begin
        c.position = POS_W'($urandom_range(list_len - 1));
      end
    end else begin
      c.op = CMD_SEARCH;
      if (list_len > 0 && $urandom_range(1) == 1) begin
        c.value = list_mem[IDX_W'($urandom_range(list_len - 1))];
      end
    end
    return c;
  endfunction

  // Present one word, hold it until taken, then log its predicted result.
  task automatic issue_command(list_cmd_t c, bit typed, list_result_t typed_res);
    list_result_t r;
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W-POS_W-DATA_W){1'b0}}, c.position, c.value};
    s_axis_tuser  <= c.op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = apply_command(c);
    if (r.entry_count == DEPTH[POS_W-1:0]) hit_full = 1'b1;
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, and the result check at each taken word.
  always @(posedge clk_i) begin
    list_result_t want;
    m_axis_tready <= ($urandom_range(99) >= sink_idle);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: tdata %h, tuser %0d", m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tdata[0] !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, m_axis_tdata[0]);
          mismatches++;
        end
        if (m_axis_tdata[POS_W:1] !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count,
                 m_axis_tdata[POS_W:1]);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: give up after a long stretch with no word moving on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    list_cmd_t    c;
    list_result_t t;
    int unsigned  n;
    int unsigned  extra;
    list_len     = 0;
    hit_full     = 1'b0;
    src_idle     = 30;
    sink_idle    = 86;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      c.op          = script[i].op;
      c.value       = script[i].value;
      c.position    = script[i].position;
      t.status      = script[i].status;
      t.found       = script[i].found;
      t.entry_count = script[i].entry_count;
      issue_command(c, script[i].typed, t);
    end
    for (n = 0; n < 40; n++) issue_command(make_command(50, 25), 1'b0, t);
    drain_results();

    // Fill the list, then keep pressing inserts against the full limit.
    src_idle  = 86;
    sink_idle = 30;
    n         = 0;
    extra     = 0;
    while (extra < 20 && n < 400) begin
      issue_command(make_command(95, 2), 1'b0, t);
      n++;
      if (hit_full) extra++;
    end
    drain_results();

    src_idle  = 0;
    sink_idle = 0;
    for (n = 0; n < 60; n++) issue_command(make_command(25, 55), 1'b0, t);
    drain_results();
    repeat (TAIL_WAIT) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
